FILE: hdl/tlvs_pkg.sv
// Shared types and constants for the TLV item search block.
// No dependencies; the front, queue, back, top level and testbench import this package.
`default_nettype none

package tlvs_pkg;

  // Widths of the byte position counter and the decoded length
  localparam int POS_BITS = 16;
  localparam int LEN_BITS = 32;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  // Result status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  // One classified byte as it travels through the queue
  typedef struct packed {
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                more;       // SDNV continuation bit of this byte
    logic [POS_BITS-1:0] pos;
  } tlvs_entry_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } tlvs_qstat_t;

endpackage

`default_nettype wire

FILE: hdl/tlvs_byte_if.sv
// Byte channel interface: valid/ready handshake with one buffer byte per beat.
// Depends on nothing.
`default_nettype none

interface tlvs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlvs_result_if.sv
// Result channel interface: valid/ready handshake with one search report per beat.
// Depends on nothing.
`default_nettype none

interface tlvs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] value_offset;
  logic [31:0] value_length;

  modport source (output valid, output status, output value_offset, output value_length,
                  input ready);
  modport sink   (input valid, input status, input value_offset, input value_length,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/tlvs_front.sv
// Front end: accepts buffer bytes, tags each with its position and continuation bit.
// Depends on tlvs_pkg and tlvs_byte_if.
`default_nettype none

module tlvs_front
  import tlvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tlvs_byte_if.sink     feed,
  input  tlvs_qstat_t   qstat,
  output logic          push,
  output tlvs_entry_t   push_entry
);

  logic [POS_BITS-1:0] pos;

  // Accept a beat whenever the queue has room
  assign feed.ready = !qstat.full;
  assign push       = feed.valid && feed.ready;

  // Classify the byte
  always_comb begin
    push_entry.data_byte = feed.data_byte;
    push_entry.last_byte = feed.last_byte;
    push_entry.more      = feed.data_byte[7];
    push_entry.pos       = pos;
  end

  // Advance the position; restart at each buffer end
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      if (feed.last_byte) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlvs_queue.sv
// Short queue between front and back so that each side stalls on its own.
// Depends on tlvs_pkg.
`default_nettype none

module tlvs_queue
  import tlvs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  tlvs_entry_t push_entry,
  input  wire logic   pop,
  output tlvs_entry_t head,
  output tlvs_qstat_t qstat
);

  tlvs_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tlvs_back.sv
// Back end: walks the TLV phases one queued byte per cycle unless a report waits untaken; drives the result register.
// Depends on tlvs_pkg and tlvs_result_if.
`default_nettype none

module tlvs_back
  import tlvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  tlvs_entry_t      head,
  input  tlvs_qstat_t      qstat,
  output logic             pop,
  tlvs_result_if.source    report
);

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [7:0]          wanted_type;
  logic [1:0]          phase, phase_next;
  logic [7:0]          current_type, current_type_next;
  logic [LEN_BITS-1:0] acc, acc_next;
  logic [LEN_BITS-1:0] skip, skip_next;
  logic [LEN_BITS-1:0] shifted;
  logic [LEN_BITS-1:0] skip_dec;
  logic                emit;
  logic [1:0]          emit_status;
  logic [POS_BITS-1:0] emit_offset;
  logic [LEN_BITS-1:0] emit_length;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [POS_BITS-1:0] out_offset;
  logic [LEN_BITS-1:0] out_length;

  // Take a queued byte when the result register is free or draining
  assign pop = !qstat.empty && (!out_valid || report.ready);

  assign shifted  = {acc[LEN_BITS-8:0], head.data_byte[6:0]};
  assign skip_dec = (skip != '0) ? (skip - 1'b1) : skip;

  // Phase update for the byte at the queue head
  always_comb begin
    phase_next        = phase;
    current_type_next = current_type;
    acc_next          = acc;
    skip_next         = skip;
    emit              = 1'b0;
    emit_status       = ST_ABSENT;
    emit_offset       = '0;
    emit_length       = '0;
    unique case (phase)
      PH_TYPE: begin
        current_type_next = head.data_byte;
        acc_next          = '0;
        phase_next        = PH_LEN;
        if (head.last_byte) begin
          emit        = 1'b1;
          emit_status = ST_BAD;
        end
      end
      PH_LEN: begin
        if (acc[LEN_BITS-1:LEN_BITS-7] != '0) begin
          // Length would overflow: report malformed, ignore the rest
          emit        = 1'b1;
          emit_status = ST_BAD;
          phase_next  = PH_DONE;
        end else begin
          acc_next = shifted;
          if (head.more) begin
            if (head.last_byte) begin
              emit        = 1'b1;
              emit_status = ST_BAD;
            end
          end else if (shifted == '0) begin
            phase_next = PH_TYPE;
            if (head.last_byte) begin
              emit        = 1'b1;
              emit_status = ST_ABSENT;
            end
          end else if (current_type == wanted_type) begin
            emit        = 1'b1;
            emit_status = ST_FOUND;
            emit_offset = head.pos + 1'b1;
            emit_length = shifted;
            phase_next  = PH_DONE;
          end else begin
            skip_next  = shifted;
            phase_next = PH_SKIP;
            if (head.last_byte) begin
              emit        = 1'b1;
              emit_status = ST_ABSENT;
            end
          end
        end
      end
      PH_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_TYPE;
        end
        if (head.last_byte) begin
          emit        = 1'b1;
          emit_status = ST_ABSENT;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    // Drop all state at the buffer end
    if (head.last_byte) begin
      phase_next        = PH_TYPE;
      current_type_next = '0;
      acc_next          = '0;
      skip_next         = '0;
    end
  end

  // Hold the wanted type
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type <= '0;
    end else if (cfg_we) begin
      wanted_type <= cfg_data;
    end
  end

  // Advance the phase state on each popped byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      current_type <= '0;
      acc          <= '0;
      skip         <= '0;
    end else if (pop) begin
      phase        <= phase_next;
      current_type <= current_type_next;
      acc          <= acc_next;
      skip         <= skip_next;
    end
  end

  // Result register: load on a report, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_status <= emit_status;
      out_offset <= emit_offset;
      out_length <= emit_length;
    end
  end

  assign report.valid        = out_valid;
  assign report.status       = out_status;
  assign report.value_offset = out_offset;
  assign report.value_length = out_length;

endmodule

`default_nettype wire

FILE: hdl/tlv_sdnv_item_search.sv
// Top level of the TLV item search: front end, byte queue and phase back end.
// Depends on tlvs_pkg, tlvs_byte_if, tlvs_result_if, tlvs_front, tlvs_queue, tlvs_back.
`default_nettype none

// Takes one buffer byte per clock cycle while the queue has room and gives at most
// one report per buffer: found (with value offset and length) at the byte that
// completes the first matching nonzero length, malformed at once on an oversized
// length, otherwise absent or malformed at the buffer's last byte. A report is
// registered in the result register and waits behind any bytes queued ahead of its
// byte. Throughput is one byte per cycle while reports are taken, set by the phase
// update in the back end; the four-beat queue keeps input flowing while a report
// waits, until it is full. The user writes wanted_type through cfg_we/cfg_data only
// while no buffer is in flight; the block itself does not enforce this.
module tlv_sdnv_item_search
  import tlvs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  tlvs_byte_if.sink       feed,
  tlvs_result_if.source   report
);

  logic        push;
  logic        pop;
  tlvs_entry_t push_entry;
  tlvs_entry_t head;
  tlvs_qstat_t qstat;

  tlvs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feed       (feed),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  tlvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  tlvs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .report   (report)
  );

  // Never take a beat into a full queue
  assert property (@(posedge clk) disable iff (rst) qstat.full |-> !feed.ready)
    else $error("byte accepted while queue full");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A found report always carries a nonzero length
  assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.status == ST_FOUND) |-> report.value_length != '0)
    else $error("found report with zero length");

  // Absent and malformed reports carry zero offset and length
  assert property (@(posedge clk) disable iff (rst)
    (report.valid && report.status != ST_FOUND) |->
      (report.value_offset == '0 && report.value_length == '0))
    else $error("non-found report with payload");

  // No report right after reset
  assert property (@(posedge clk) $past(rst) |-> !report.valid)
    else $error("report valid after reset");

endmodule

`default_nettype wire

FILE: tb/tlv_sdnv_item_search_test.sv
// Self-checking testbench for tlv_sdnv_item_search: directed TLV buffers, then random ones.
// Depends on tlvs_pkg, tlvs_byte_if, tlvs_result_if and the tlv_sdnv_item_search RTL.
`default_nettype none

module tlv_sdnv_item_search_test;
  import tlvs_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int SETTLE       = 16;
  localparam int PHASE_BYTES  = 145;

  // Scan state of the buffer walker
  typedef enum logic [1:0] {SEEK_TYPE, IN_LEN, SKIP_VAL, DONE_BUF} scan_phase_t;

  // Receiver stall behavior over one stretch
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [POS_BITS-1:0] offset;
    logic [LEN_BITS-1:0] length;
  } report_t;

  // Directed stimulus: byte, last flag, and a typed expectation where one is given
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic       has;
    report_t    rep;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_data;

  tlvs_byte_if   byte_ch ();
  tlvs_result_if rpt_ch ();

  tlv_sdnv_item_search uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .feed     (byte_ch),
    .report   (rpt_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register and the scan state
  logic [7:0]          want_type;
  scan_phase_t         scan_phase;
  logic [7:0]          item_type;
  logic [LEN_BITS-1:0] len_acc;
  logic [LEN_BITS-1:0] skip_left;
  logic [POS_BITS-1:0] byte_pos;

  report_t    reports_due[$];
  logic [7:0] buf_q[$];
  dir_row_t   dir_rows[26];

  int  fail_count = 0;
  int  stuck_cycles = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  // Advance the shadow scan by one byte; return 1 when the byte yields a report
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output report_t rep);
    bit hit;
    hit = 1'b0;
    rep = '0;
    case (scan_phase)
      SEEK_TYPE: begin
        item_type  = b;
        len_acc    = '0;
        scan_phase = IN_LEN;
        if (last) begin
          hit = 1'b1;
          rep.status = ST_BAD;
        end
      end
      IN_LEN: begin
        if (len_acc[LEN_BITS-1:LEN_BITS-7] != '0) begin
          // another group would overflow the length
          hit = 1'b1;
          rep.status = ST_BAD;
          scan_phase = DONE_BUF;
        end else begin
          len_acc = {len_acc[LEN_BITS-8:0], b[6:0]};
          if (b[7]) begin
            if (last) begin
              hit = 1'b1;
              rep.status = ST_BAD;
            end
          end else if (len_acc == '0) begin
            scan_phase = SEEK_TYPE;
            if (last) begin
              hit = 1'b1;
              rep.status = ST_ABSENT;
            end
          end else if (item_type == want_type) begin
            hit = 1'b1;
            rep.status = ST_FOUND;
            rep.offset = byte_pos + 1'b1;
            rep.length = len_acc;
            scan_phase = DONE_BUF;
          end else begin
            skip_left  = len_acc;
            scan_phase = SKIP_VAL;
            if (last) begin
              hit = 1'b1;
              rep.status = ST_ABSENT;
            end
          end
        end
      end
      SKIP_VAL: begin
        if (skip_left != '0) skip_left = skip_left - 1'b1;
        if (skip_left == '0) scan_phase = SEEK_TYPE;
        if (last) begin
          hit = 1'b1;
          rep.status = ST_ABSENT;
        end
      end
      default: ;
    endcase
    // Clear everything at the end of a buffer
    if (last) begin
      scan_phase = SEEK_TYPE;
      item_type  = '0;
      len_acc    = '0;
      skip_left  = '0;
      byte_pos   = '0;
    end else begin
      byte_pos = byte_pos + 1'b1;
    end
    return hit;
  endfunction

  // Offer one beat, idling first when gaps are on and the burst is used up, and log any report
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input bit typed_has, input report_t typed_rep);
    report_t rep;
    bit      hit;
    if (gaps_on && burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    hit = scan_byte(b, last, rep);
    if (typed) begin
      hit = typed_has;
      rep = typed_rep;
    end
    if (hit) reports_due.push_back(rep);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < buf_q.size(); i++)
      send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, 1'b0, '0);
  endtask

  // Append an SDNV length, sometimes with a leading empty group
  task automatic push_sdnv(input logic [31:0] len);
    int groups;
    groups = 1;
    while (groups < 5 && (len >> (7 * groups)) != 0) groups++;
    if ($urandom_range(0, 7) == 0) buf_q.push_back(8'h80);
    for (int g = groups - 1; g >= 0; g--)
      buf_q.push_back(8'((len >> (7 * g)) & 32'h7F) | ((g != 0) ? 8'h80 : 8'h00));
  endtask

  task automatic write_wanted(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    want_type = v;
  endtask

  // Drop valid, wait for every report, then let trailing ignored bytes drain
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: stretches of open, coin-flip and sparse ready, plus one long hold-off
  initial begin
    int       stretch;
    rx_mode_t mode;
    stretch = 0;
    mode    = RX_OPEN;
    rpt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rpt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = rx_mode_t'($urandom_range(0, 2));
          stretch = $urandom_range(10, 60);
        end
        stretch--;
        case (mode)
          RX_OPEN: rpt_ch.ready <= 1'b1;
          RX_COIN: rpt_ch.ready <= 1'($urandom_range(0, 1));
          default: rpt_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted report with the oldest one due
  always @(posedge clk) begin : check_reports
    report_t got;
    report_t due;
    if (!rst && rpt_ch.valid && rpt_ch.ready) begin
      got.status = rpt_ch.status;
      got.offset = rpt_ch.value_offset;
      got.length = rpt_ch.value_length;
      if (reports_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected report: status %0d offset %0d length %0h",
                   got.status, got.offset, got.length);
      end else begin
        due = reports_due.pop_front();
        if (got.status !== due.status || got.offset !== due.offset ||
            got.length !== due.length) begin
          fail_count++;
          if (fail_count <= 10)
            $display("report mismatch: expected status %0d offset %0d length %0h, got status %0d offset %0d length %0h",
                     due.status, due.offset, due.length, got.status, got.offset, got.length);
        end
      end
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (rpt_ch.valid && rpt_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main stimulus
  initial begin
    int         kind;
    int         n_items;
    int         cut;
    int         phase_bytes;
    logic [7:0] t;
    logic [31:0] len;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_data          <= 8'h00;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    want_type  = 8'h00;
    scan_phase = SEEK_TYPE;
    item_type  = '0;
    len_acc    = '0;
    skip_left  = '0;
    byte_pos   = '0;

    dir_rows = '{
      // matching item found at its length byte, rest ignored
      '{8'h05, 1'b0, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b1, 1'b1, '{ST_FOUND, 16'd2, 32'd3}},
      '{8'hAA, 1'b1, 1'b1, 1'b0, '0},
      // buffer ends after a type byte
      '{8'h05, 1'b1, 1'b1, 1'b1, '{ST_BAD, 16'd0, 32'd0}},
      // buffer ends inside a length
      '{8'h07, 1'b0, 1'b0, 1'b0, '0},
      '{8'h81, 1'b1, 1'b1, 1'b1, '{ST_BAD, 16'd0, 32'd0}},
      // zero-length matching item skipped, clean end
      '{8'h05, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, 1'b1, '{ST_ABSENT, 16'd0, 32'd0}},
      // skipped value runs past the end
      '{8'h09, 1'b0, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, 1'b0, '0},
      '{8'h11, 1'b1, 1'b1, 1'b1, '{ST_ABSENT, 16'd0, 32'd0}},
      // buffer ends right after a nonmatching length
      '{8'h09, 1'b0, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b1, 1'b1, '{ST_ABSENT, 16'd0, 32'd0}},
      // oversized length: malformed at once, then silence
      '{8'h05, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, 1'b1, '{ST_BAD, 16'd0, 32'd0}},
      '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
      // largest length that fits in 32 bits
      '{8'h05, 1'b0, 1'b0, 1'b0, '0},
      '{8'h8F, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b1, 1'b1, '{ST_FOUND, 16'd6, 32'hFFFF_FFFF}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_wanted(8'h05);
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].has,
                dir_rows[i].rep);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_wanted((ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom));

      // Hold off the receiver while short buffers keep arriving back to back
      if (ph == 0) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40) begin
          buf_q = '{8'($urandom), 8'($urandom_range(0, 127))};
          send_buffer();
        end
        gaps_on = 1'b1;
      end

      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        buf_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          // well-formed items, some cut short
          n_items = $urandom_range(1, 4);
          for (int i = 0; i < n_items; i++) begin
            t = ($urandom_range(0, 2) == 0) ? want_type : 8'($urandom);
            case ($urandom_range(0, 9))
              0, 1: len = 32'd0;
              2: len = (t == want_type) ? 32'($urandom) : 32'($urandom_range(7, 40));
              default: len = 32'($urandom_range(1, 6));
            endcase
            buf_q.push_back(t);
            push_sdnv(len);
            // a found value is never walked, so keep it short
            if (t == want_type && len > 6) len = 32'($urandom_range(0, 3));
            repeat (len) buf_q.push_back(8'($urandom));
          end
          if (kind >= 60) begin
            cut = $urandom_range(1, buf_q.size());
            while (buf_q.size() > cut) void'(buf_q.pop_back());
          end
        end else if (kind < 85) begin
          repeat ($urandom_range(1, 16)) buf_q.push_back(8'($urandom));
        end else if (kind < 95) begin
          // length with too many significant groups
          buf_q.push_back($urandom_range(0, 1) ? want_type : 8'($urandom));
          buf_q.push_back(8'($urandom_range(8'h90, 8'hFF)));
          repeat (3) buf_q.push_back(8'($urandom) | 8'h80);
          repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
        end else begin
          buf_q = '{($urandom_range(0, 1) ? want_type : 8'($urandom)),
                    8'($urandom_range(0, 127))};
        end
        phase_bytes += buf_q.size();
        send_buffer();
      end
      wait_drained();
    end

    byte_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/tlvs_pkg.sv
hdl/tlvs_byte_if.sv
hdl/tlvs_result_if.sv
hdl/tlvs_front.sv
hdl/tlvs_queue.sv
hdl/tlvs_back.sv
hdl/tlv_sdnv_item_search.sv
tb/tlv_sdnv_item_search_test.sv
